// ===== sv/vr_pkg.sv =====
// ----------------------------------------------------------------------------
// vr_pkg: shared types and widths for the vector refraction block
// Fixed-point formats, derived datapath widths and the item structs.
// ----------------------------------------------------------------------------
package vr_pkg;

    // Fraction bits of the fixed-point vectors, eta and results; k carries twice as many
    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 20;

    // Derived datapath widths
    localparam int PROD_W = 2 * IN_W;
    localparam int DOT_W  = PROD_W + 2;
    localparam int D_W    = DOT_W - FRAC_BITS;
    localparam int ED_W   = IN_W + 1 + D_W;
    localparam int ENI_W  = ED_W - FRAC_BITS;
    localparam int SQ_W   = 2 * ENI_W;
    localparam int KW_RAW = ((SQ_W > 2 * FRAC_BITS) ? SQ_W : 2 * FRAC_BITS + 1) + 1;
    localparam int KW     = KW_RAW + (KW_RAW % 2);
    localparam int SW     = KW / 2;
    localparam int RW     = SW + 2;
    localparam int C_W    = ((ENI_W > SW + 1) ? ENI_W : SW + 1) + 1;
    localparam int EA_W   = 2 * IN_W + 1;
    localparam int CN_W   = C_W + IN_W;
    localparam int R_W    = ((CN_W > EA_W) ? CN_W : EA_W) + 1;
    localparam int RR_W   = R_W - FRAC_BITS;
    localparam int HALF   = 1 << (FRAC_BITS - 1);

    typedef struct packed {
        logic signed [IN_W-1:0] inc_x;
        logic signed [IN_W-1:0] inc_y;
        logic signed [IN_W-1:0] inc_z;
        logic signed [IN_W-1:0] nrm_x;
        logic signed [IN_W-1:0] nrm_y;
        logic signed [IN_W-1:0] nrm_z;
        logic        [IN_W-1:0] ratio_eta;
    } vr_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] res_x;
        logic signed [OUT_W-1:0] res_y;
        logic signed [OUT_W-1:0] res_z;
        logic                    refracted;
    } vr_out_t;

    // Side data that rides along the square-root chain
    typedef struct packed {
        vr_in_t                  item;
        logic signed [ENI_W-1:0] eni;
        logic                    tir;
    } vr_side_t;

    // Working state of one square-root step
    typedef struct packed {
        logic [KW-1:0] rad;
        logic [RW-1:0] rem;
        logic [SW-1:0] root;
    } vr_sqrt_t;

endpackage

// ===== sv/vr_front.sv =====
// ----------------------------------------------------------------------------
// vr_front: dot product, eta scaling and discriminant
// Five registered stages from the input item to k and the reflection flag.
// ----------------------------------------------------------------------------
module vr_front
    import vr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     valid_i,
    input  vr_in_t   item_i,
    output logic     valid_o,
    output vr_side_t side_o,
    output vr_sqrt_t sq_o
);

    localparam logic [KW-1:0] ONE_K = KW'(1) << (2 * FRAC_BITS);

    logic [4:0]               v_reg;
    vr_in_t                   item_reg [5];
    logic signed [PROD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [D_W-1:0]    d_reg;
    logic signed [ED_W-1:0]   ed_reg;
    logic signed [ENI_W-1:0]  eni4_reg, eni5_reg;
    logic [SQ_W-1:0]          eni2_reg;
    logic [PROD_W-1:0]        e2_reg;
    logic [KW-1:0]            k_reg;
    logic                     tir_reg;

    logic signed [DOT_W-1:0]  dot, dot_rnd;
    logic signed [D_W-1:0]    d_next;
    logic signed [ED_W-1:0]   ed_next, ed_rnd;
    logic signed [ENI_W-1:0]  eni_next;
    logic [ENI_W-1:0]         mag;
    logic [KW-1:0]            tot;

    // dot product sum and rounding
    always_comb
    begin
        dot     = DOT_W'(px_reg) + DOT_W'(py_reg) + DOT_W'(pz_reg);
        dot_rnd = dot + DOT_W'(HALF);
        d_next  = D_W'(dot_rnd >>> FRAC_BITS);
    end

    // eta times d, rounded, and its magnitude
    always_comb
    begin
        ed_next  = $signed({1'b0, item_reg[1].ratio_eta}) * d_reg;
        ed_rnd   = ed_reg + ED_W'(HALF);
        eni_next = ENI_W'(ed_rnd >>> FRAC_BITS);
        mag      = eni_next[ENI_W-1] ? ENI_W'(-eni_next) : ENI_W'(eni_next);
    end

    // 1 + (eta*d)^2 ahead of the compare with eta^2
    assign tot = KW'(eni2_reg) + ONE_K;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], valid_i};
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg[0] <= item_i;
            px_reg      <= item_i.nrm_x * item_i.inc_x;
            py_reg      <= item_i.nrm_y * item_i.inc_y;
            pz_reg      <= item_i.nrm_z * item_i.inc_z;

            item_reg[1] <= item_reg[0];
            d_reg       <= d_next;

            item_reg[2] <= item_reg[1];
            ed_reg      <= ed_next;

            item_reg[3] <= item_reg[2];
            eni4_reg    <= eni_next;
            eni2_reg    <= mag * mag;
            e2_reg      <= item_reg[2].ratio_eta * item_reg[2].ratio_eta;

            item_reg[4] <= item_reg[3];
            eni5_reg    <= eni4_reg;
            tir_reg     <= tot < KW'(e2_reg);
            k_reg       <= (tot < KW'(e2_reg)) ? '0 : tot - KW'(e2_reg);
        end
    end

    assign valid_o      = v_reg[4];
    assign side_o.item  = item_reg[4];
    assign side_o.eni   = eni5_reg;
    assign side_o.tir   = tir_reg;
    assign sq_o.rad     = k_reg;
    assign sq_o.rem     = '0;
    assign sq_o.root    = '0;

endmodule

// ===== sv/vr_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// vr_sqrt_cell: one step of the digit-by-digit square root
// Takes two radicand bits, yields one root bit, and hands on to the next cell.
// ----------------------------------------------------------------------------
module vr_sqrt_cell
    import vr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     valid_i,
    input  vr_side_t side_i,
    input  vr_sqrt_t sq_i,
    output logic     valid_o,
    output vr_side_t side_o,
    output vr_sqrt_t sq_o
);

    logic            valid_reg;
    vr_side_t        side_reg;
    vr_sqrt_t        sq_reg;
    vr_sqrt_t        sq_next;
    logic [RW+1:0]   shifted;
    logic [RW+1:0]   trial;

    // trial subtract of (4*root + 1)
    always_comb
    begin
        shifted      = {sq_i.rem, sq_i.rad[KW-1 -: 2]};
        trial        = {2'b00, sq_i.root, 2'b01};
        sq_next.rad  = {sq_i.rad[KW-3:0], 2'b00};
        if (shifted >= trial)
        begin
            sq_next.rem  = RW'(shifted - trial);
            sq_next.root = {sq_i.root[SW-2:0], 1'b1};
        end
        else
        begin
            sq_next.rem  = RW'(shifted);
            sq_next.root = {sq_i.root[SW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_i;
            sq_reg   <= sq_next;
        end
    end

    assign valid_o = valid_reg;
    assign side_o  = side_reg;
    assign sq_o    = sq_reg;

endmodule

// ===== sv/vr_back.sv =====
// ----------------------------------------------------------------------------
// vr_back: root rounding, refracted vector and saturation
// Three registered stages from the finished root to the result item.
// ----------------------------------------------------------------------------
module vr_back
    import vr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     valid_i,
    input  vr_side_t side_i,
    input  vr_sqrt_t sq_i,
    output logic     valid_o,
    output vr_out_t  item_o
);

    localparam logic signed [RR_W-1:0] SAT_HI = RR_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [RR_W-1:0] SAT_LO = RR_W'(-(1 << (OUT_W - 1)));

    logic [2:0]              v_reg;
    vr_in_t                  item1_reg;
    logic                    tir1_reg, tir2_reg;
    logic signed [C_W-1:0]   c_reg;
    logic signed [EA_W-1:0]  ea_reg [3];
    logic signed [CN_W-1:0]  cn_reg [3];
    vr_out_t                 out_reg;

    logic [SW:0]             s;
    logic signed [C_W-1:0]   c_next;

    // round the root to nearest: bump when the remainder exceeds it
    always_comb
    begin
        s      = {1'b0, sq_i.root} + (SW + 1)'(sq_i.rem > RW'(sq_i.root));
        c_next = C_W'(side_i.eni) + C_W'(s);
    end

    function automatic logic signed [OUT_W-1:0] sat_round(
        input logic signed [EA_W-1:0] ea,
        input logic signed [CN_W-1:0] cn
    );
        logic signed [R_W-1:0]  r;
        logic signed [RR_W-1:0] rr;
        r  = R_W'(ea) - R_W'(cn) + R_W'(HALF);
        rr = RR_W'(r >>> FRAC_BITS);
        if (rr > SAT_HI)
            sat_round = SAT_HI[OUT_W-1:0];
        else if (rr < SAT_LO)
            sat_round = SAT_LO[OUT_W-1:0];
        else
            sat_round = rr[OUT_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], valid_i};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item1_reg <= side_i.item;
            tir1_reg  <= side_i.tir;
            c_reg     <= c_next;

            // eta*I and c*N per component
            tir2_reg  <= tir1_reg;
            ea_reg[0] <= $signed({1'b0, item1_reg.ratio_eta}) * item1_reg.inc_x;
            ea_reg[1] <= $signed({1'b0, item1_reg.ratio_eta}) * item1_reg.inc_y;
            ea_reg[2] <= $signed({1'b0, item1_reg.ratio_eta}) * item1_reg.inc_z;
            cn_reg[0] <= c_reg * item1_reg.nrm_x;
            cn_reg[1] <= c_reg * item1_reg.nrm_y;
            cn_reg[2] <= c_reg * item1_reg.nrm_z;

            // total reflection gives a zero vector
            if (tir2_reg)
            begin
                out_reg <= '0;
            end
            else
            begin
                out_reg.res_x     <= sat_round(ea_reg[0], cn_reg[0]);
                out_reg.res_y     <= sat_round(ea_reg[1], cn_reg[1]);
                out_reg.res_z     <= sat_round(ea_reg[2], cn_reg[2]);
                out_reg.refracted <= 1'b1;
            end
        end
    end

    assign valid_o = v_reg[2];
    assign item_o  = out_reg;

endmodule

// ===== sv/vector_refract.sv =====
// ----------------------------------------------------------------------------
// vector_refract: Snell refraction of a direction vector, fixed point
// Pipeline front end, a chain of square-root cells, back end and output skid.
// ----------------------------------------------------------------------------
// Takes one item per clock while src_stall is low and gives one result per
// item, in order. From acceptance to the output, each item passes through
// five front stages, one square-root cell per root bit (SW = 24 cells),
// three back stages and the output register. A two-entry output buffer
// (output register plus skid) lets the pipeline keep running while one
// result waits; src_stall rises only when both are full.
module vector_refract
    import vr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    src_valid,
    output logic    src_stall,
    input  vr_in_t  src_item,
    output logic    dst_valid,
    input  logic    dst_stall,
    output vr_out_t dst_item
);

    logic      adv;
    logic      valid_c [SW+1];
    vr_side_t  side_c  [SW+1];
    vr_sqrt_t  sq_c    [SW+1];
    logic      pipe_valid;
    vr_out_t   pipe_item;

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    vr_out_t   out_reg, skid_reg;
    logic      load_out, load_skid, take;

    // the whole pipeline moves while the skid stage is free
    assign adv       = !skid_valid_reg;
    assign src_stall = skid_valid_reg;

    vr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .valid_i (src_valid),
        .item_i  (src_item),
        .valid_o (valid_c[0]),
        .side_o  (side_c[0]),
        .sq_o    (sq_c[0])
    );

    // one cell per root bit
    for (genvar i = 0; i < SW; i++)
    begin : g_cell
        vr_sqrt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .valid_i (valid_c[i]),
            .side_i  (side_c[i]),
            .sq_i    (sq_c[i]),
            .valid_o (valid_c[i+1]),
            .side_o  (side_c[i+1]),
            .sq_o    (sq_c[i+1])
        );
    end

    vr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .valid_i (valid_c[SW]),
        .side_i  (side_c[SW]),
        .sq_i    (sq_c[SW]),
        .valid_o (pipe_valid),
        .item_o  (pipe_item)
    );

    // output register and skid stage
    always_comb
    begin
        take            = out_valid_reg && !dst_stall;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (take)
        begin
            out_valid_next  = skid_valid_reg;
            skid_valid_next = 1'b0;
        end
        if (adv && pipe_valid)
        begin
            if (!out_valid_reg || take)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_reg <= pipe_item;
        else if (take && skid_valid_reg)
            out_reg <= skid_reg;
        if (load_skid)
            skid_reg <= pipe_item;
    end

    assign dst_valid = out_valid_reg;
    assign dst_item  = out_reg;

    // skid only ever holds an item behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while the output register is empty");

    // skid fills only when the output was stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(dst_stall))
        else $error("skid filled without an output stall");

    // total internal reflection answers a zero vector
    a_tir_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !dst_item.refracted) |->
            (dst_item.res_x == '0 && dst_item.res_y == '0 && dst_item.res_z == '0))
        else $error("reflected item carries a non-zero vector");

endmodule
